// ===== rtl/cpqp_pkg.sv =====
package cpqp_pkg;

    localparam int HANDLE_W = 16;
    localparam int WORD_W = 64;
    localparam logic [HANDLE_W-1:0] BASE_RESET = 16'hB00;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_POST   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLOSE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HANDLE = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_NO_PORT    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_EMIT
    } state_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [HANDLE_W-1:0] handle;
        logic [WORD_W-1:0]   key_word;
        logic [WORD_W-1:0]   ctx_word;
        logic [WORD_W-1:0]   stat_word;
        logic [WORD_W-1:0]   information;
    } in_item_t;

    typedef struct packed {
        status_t             result_status;
        logic [HANDLE_W-1:0] new_handle;
        logic [WORD_W-1:0]   out_key;
        logic [WORD_W-1:0]   out_context;
        logic [WORD_W-1:0]   out_status;
        logic [WORD_W-1:0]   out_information;
        logic                overflow_dropped;
    } out_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] pkt_key;
        logic [WORD_W-1:0] pkt_ctx;
        logic [WORD_W-1:0] pkt_status;
        logic [WORD_W-1:0] pkt_info;
    } packet_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic set_active;
        logic clr_active;
    } tbl_ctl_t;

endpackage

// ===== rtl/cpqp_chan_if.sv =====
interface cpqp_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// ===== rtl/cpqp_port_table.sv =====
module cpqp_port_table
    import cpqp_pkg::*;
#(
    parameter int PORT_COUNT = 8,
    parameter int IDX_W = 3,
    parameter int PTR_W = 4,
    parameter int FILL_W = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tbl_ctl_t          ctl,
    input  logic [IDX_W-1:0]  rd_idx,
    input  logic [IDX_W-1:0]  wr_idx,
    input  logic [PTR_W-1:0]  wr_wp,
    input  logic [PTR_W-1:0]  wr_rp,
    input  logic [FILL_W-1:0] wr_fill,
    output logic [PTR_W-1:0]  rd_wp,
    output logic [PTR_W-1:0]  rd_rp,
    output logic [FILL_W-1:0] rd_fill,
    input  logic [IDX_W-1:0]  look_idx,
    output logic              look_active,
    output logic              free_found,
    output logic [IDX_W-1:0]  free_idx
);

    localparam int ENT_W = 2 * PTR_W + FILL_W;

    logic [ENT_W-1:0]      ptr_mem [PORT_COUNT];
    logic [ENT_W-1:0]      rd_data_reg;
    logic [PORT_COUNT-1:0] active_reg;
    logic [PORT_COUNT-1:0] active_next;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            ptr_mem[wr_idx] <= {wr_wp, wr_rp, wr_fill};
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= ptr_mem[rd_idx];
        end
    end

    assign rd_wp   = rd_data_reg[ENT_W-1 -: PTR_W];
    assign rd_rp   = rd_data_reg[FILL_W +: PTR_W];
    assign rd_fill = rd_data_reg[FILL_W-1:0];

    always_comb
    begin
        active_next = active_reg;
        if (ctl.set_active)
        begin
            active_next[wr_idx] = 1'b1;
        end
        if (ctl.clr_active)
        begin
            active_next[wr_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    assign look_active = active_reg[look_idx];

    // lowest free port wins
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = PORT_COUNT - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

endmodule

// ===== rtl/cpqp_pkt_ram.sv =====
module cpqp_pkt_ram
    import cpqp_pkg::*;
#(
    parameter int ADDR_W = 7
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  packet_t           wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output packet_t           rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    packet_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/completion_port_queue_pool.sv =====
// Pool of completion ports, each a ring of four-word packets.
// cmd carries one command transaction (create, post, remove, close) with its
// handle and packet words; rsp returns exactly one result transaction per
// command, in order. cfg_we/cfg_wdata set the first handle number; the user
// must write it only while idle; the block itself does not enforce this.
// One command is worked on at a time: the pointer memory is read on accept,
// S_EXEC works the command, S_FETCH reads the packet memory for a remove that
// returns a packet, then S_EMIT loads the output register and returns to idle.
// The result sits in an output register: a new command is accepted while it
// waits for rsp.ready, and the next result is held inside until that register
// drains, with cmd.ready low meanwhile.
// Reset clears the in-use flags and sets the handle base to 0xB00; there is
// no clearing pass, ring slots and pointers are written before they are read.
module completion_port_queue_pool
    import cpqp_pkg::*;
#(
    parameter int PORT_COUNT = 8,
    parameter int RING_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [HANDLE_W-1:0] cfg_wdata,
    cpqp_chan_if.sink           cmd,
    cpqp_chan_if.source         rsp
);

    localparam int IDX_W  = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int ADDR_W = IDX_W + PTR_W;

    state_t              state_reg, state_next;
    logic [HANDLE_W-1:0] base_reg;
    opcode_t             op_reg;
    logic                hit_reg;
    logic [IDX_W-1:0]    idx_reg;
    packet_t             pkt_reg;
    out_item_t           res_reg, res_next;
    out_item_t           out_reg;
    logic                out_valid_reg;
    logic                out_load;
    logic                accept;

    logic [HANDLE_W:0]   diff;
    logic                dec_ok;
    logic [IDX_W-1:0]    dec_idx;
    logic [IDX_W-1:0]    rd_idx;

    tbl_ctl_t            ctl;
    logic [PTR_W-1:0]    rd_wp, rd_rp, wr_wp, wr_rp;
    logic [FILL_W-1:0]   rd_fill, wr_fill;
    logic                look_active;
    logic                free_found;
    logic [IDX_W-1:0]    free_idx;
    logic [PTR_W-1:0]    wp_inc, rp_inc;
    logic                ring_full;

    logic                pkt_we, pkt_re;
    packet_t             pkt_rd;

    assign diff    = {1'b0, cmd.payload.handle} - {1'b0, base_reg};
    assign dec_ok  = !diff[HANDLE_W] && (diff[HANDLE_W-1:0] < HANDLE_W'(PORT_COUNT));
    assign dec_idx = diff[IDX_W-1:0];
    assign rd_idx  = (cmd.payload.opcode == OP_CREATE) ? free_idx : dec_idx;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);

    assign wp_inc    = (rd_wp == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_wp + PTR_W'(1);
    assign rp_inc    = (rd_rp == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_rp + PTR_W'(1);
    assign ring_full = (rd_fill == FILL_W'(RING_DEPTH));

    cpqp_port_table #(
        .PORT_COUNT (PORT_COUNT),
        .IDX_W      (IDX_W),
        .PTR_W      (PTR_W),
        .FILL_W     (FILL_W)
    ) u_port_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .rd_idx      (rd_idx),
        .wr_idx      (idx_reg),
        .wr_wp       (wr_wp),
        .wr_rp       (wr_rp),
        .wr_fill     (wr_fill),
        .rd_wp       (rd_wp),
        .rd_rp       (rd_rp),
        .rd_fill     (rd_fill),
        .look_idx    (idx_reg),
        .look_active (look_active),
        .free_found  (free_found),
        .free_idx    (free_idx)
    );

    cpqp_pkt_ram #(
        .ADDR_W (ADDR_W)
    ) u_pkt_ram (
        .clk     (clk),
        .wr_en   (pkt_we),
        .wr_addr ({idx_reg, rd_wp}),
        .wr_data (pkt_reg),
        .rd_en   (pkt_re),
        .rd_addr ({idx_reg, rd_rp}),
        .rd_data (pkt_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        ctl        = '0;
        wr_wp      = rd_wp;
        wr_rp      = rd_rp;
        wr_fill    = rd_fill;
        pkt_we     = 1'b0;
        pkt_re     = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    ctl.rd_en  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_next   = '0;
                state_next = S_EMIT;
                unique case (op_reg)
                    OP_CREATE:
                    begin
                        if (hit_reg)
                        begin
                            ctl.set_active      = 1'b1;
                            ctl.wr_en           = 1'b1;
                            wr_wp               = '0;
                            wr_rp               = '0;
                            wr_fill             = '0;
                            res_next.new_handle = base_reg + HANDLE_W'(idx_reg);
                        end
                        else
                        begin
                            res_next.result_status = ST_NO_PORT;
                        end
                    end
                    OP_POST:
                    begin
                        if (!hit_reg || !look_active)
                        begin
                            res_next.result_status = ST_BAD_HANDLE;
                        end
                        else
                        begin
                            // full ring: drop the oldest packet, fill stays put
                            pkt_we    = 1'b1;
                            ctl.wr_en = 1'b1;
                            wr_wp     = wp_inc;
                            wr_rp     = ring_full ? rp_inc : rd_rp;
                            wr_fill   = ring_full ? rd_fill : rd_fill + FILL_W'(1);
                            res_next.overflow_dropped = ring_full;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!hit_reg || !look_active)
                        begin
                            res_next.result_status = ST_BAD_HANDLE;
                        end
                        else if (rd_fill == '0)
                        begin
                            res_next.result_status = ST_EMPTY;
                        end
                        else
                        begin
                            pkt_re     = 1'b1;
                            ctl.wr_en  = 1'b1;
                            wr_rp      = rp_inc;
                            wr_fill    = rd_fill - FILL_W'(1);
                            state_next = S_FETCH;
                        end
                    end
                    OP_CLOSE:
                    begin
                        if (!hit_reg)
                        begin
                            res_next.result_status = ST_BAD_HANDLE;
                        end
                        else if (look_active)
                        begin
                            ctl.clr_active = 1'b1;
                            ctl.wr_en      = 1'b1;
                            wr_fill        = '0;
                        end
                    end
                    default:
                    begin
                        res_next.result_status = ST_BAD_HANDLE;
                    end
                endcase
            end
            S_FETCH:
            begin
                res_next.out_key         = pkt_rd.pkt_key;
                res_next.out_context     = pkt_rd.pkt_ctx;
                res_next.out_status      = pkt_rd.pkt_status;
                res_next.out_information = pkt_rd.pkt_info;
                state_next               = S_EMIT;
            end
            S_EMIT:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= BASE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            op_reg             <= cmd.payload.opcode;
            hit_reg            <= (cmd.payload.opcode == OP_CREATE) ? free_found : dec_ok;
            idx_reg            <= rd_idx;
            pkt_reg.pkt_key    <= cmd.payload.key_word;
            pkt_reg.pkt_ctx    <= cmd.payload.ctx_word;
            pkt_reg.pkt_status <= cmd.payload.stat_word;
            pkt_reg.pkt_info   <= cmd.payload.information;
        end
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

endmodule

// ===== rtl/cpqp_checker.sv =====
module cpqp_checker
    import cpqp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input out_item_t rsp_payload
);

    logic [1:0] pend_reg, pend_next;
    logic       cmd_acc, rsp_acc;

    assign cmd_acc = cmd_valid && cmd_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (cmd_acc && !rsp_acc)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!cmd_acc && rsp_acc)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
        else $error("result dropped or changed while stalled");

    a_rsp_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("result without an outstanding command");

    a_cmd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc |-> pend_reg <= 2'd1)
        else $error("command taken with two results outstanding");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.result_status != ST_OK |->
            rsp_payload.new_handle == '0 && rsp_payload.out_key == '0 &&
            !rsp_payload.overflow_dropped)
        else $error("failed result carries data");

    a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.overflow_dropped |->
            rsp_payload.new_handle == '0 && rsp_payload.out_information == '0)
        else $error("overflow flag on a result other than a post");

endmodule

bind completion_port_queue_pool cpqp_checker u_cpqp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
